// ===== src/htld_pkg.sv =====
// Shared types and constants of the Huffman tree loader and decoder.
`timescale 1ns / 1ps
`default_nettype none

package htld_pkg;

    localparam int IDX_W    = 9;
    localparam int SYM_W    = 8;
    localparam int ENTRY_W  = 19;
    localparam int LEAF_BIT = 18;

    typedef enum logic [1:0] {
        REQ_LEAF  = 2'd0,
        REQ_JOIN  = 2'd1,
        REQ_BIT   = 2'd2,
        REQ_CLEAR = 2'd3
    } t_req_kind;

    typedef enum logic [1:0] {
        ST_ACCEPT = 2'd0,
        ST_DONE   = 2'd1,
        ST_SYMBOL = 2'd2,
        ST_ERROR  = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        OP_REPORT   = 2'd0,
        OP_WRITE    = 2'd1,
        OP_COMPLETE = 2'd2,
        OP_WALK     = 2'd3
    } t_op;

    typedef struct packed {
        t_req_kind          req_type;
        logic [SYM_W-1:0]   symbol;
        logic               code_bit;
    } t_in_item;

    typedef struct packed {
        t_status            status;
        logic [SYM_W-1:0]   decoded_symbol;
    } t_out_item;

    // Command from the tree builder to the node table side.
    typedef struct packed {
        t_op                op;
        t_status            status;
        logic [IDX_W-1:0]   addr;
        logic [ENTRY_W-1:0] entry;
        logic               code_bit;
    } t_cmd;

endpackage

`default_nettype wire

// ===== src/huffman_tree_load_and_decode.sv =====
// Top level of the Huffman tree loader and bit-serial decoder.
`timescale 1ns / 1ps
`default_nettype none

// Channel   Direction  Handshake                       Payload
// -------   ---------  ------------------------------  ----------------------------
// request   in         push / full, taken at push&!full  i_item   (req_type, symbol, code_bit)
// result    out        empty / pop, taken at pop&!empty  o_result (status, decoded_symbol)
//
// One request transaction is taken per cycle while full is low, and every request gives
// exactly one result transaction. A result passes through the command queue, the back
// side's second stage and the result queue before it is on the result ports. The rate
// is one item per cycle when nothing stalls; it is set by the node table loop, where the
// registered read data of one code bit selects the read address of the next. Reset is
// synchronous; the node table and the build stack hold no reset values and need no
// clearing pass. Holding pop low fills the result queue and then the command queue,
// after which full rises; the request side never waits on anything else.

module huffman_tree_load_and_decode #(
    parameter int MAX_LEAVES = 256
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                push,
    output logic                full,
    input  htld_pkg::t_in_item  i_item,
    output logic                empty,
    input  logic                pop,
    output htld_pkg::t_out_item o_result
);

    import htld_pkg::*;

    localparam int MID_DEPTH = 4;
    localparam int OUT_DEPTH = 4;
    localparam int CMD_W     = $bits(t_cmd);
    localparam int RES_W     = $bits(t_out_item);
    localparam int OCW       = $clog2(OUT_DEPTH + 1);

    logic                       w_accept;
    t_cmd                       w_front_cmd;
    logic [CMD_W-1:0]           w_mid_rdata;
    t_cmd                       w_mid_cmd;
    logic                       w_mid_empty;
    logic [$clog2(MID_DEPTH+1)-1:0] w_mid_count;
    logic                       w_mid_pop;
    logic                       w_out_push;
    t_out_item                  w_out_item;
    logic                       w_out_full;
    logic [OCW-1:0]             w_out_count;
    logic [RES_W-1:0]           w_res_rdata;

    // The request is taken whenever the command queue has room.
    assign w_accept  = push && !full;
    assign w_mid_cmd = t_cmd'(w_mid_rdata);
    assign o_result  = t_out_item'(w_res_rdata);

    htld_front #(
        .MAX_LEAVES (MAX_LEAVES)
    ) u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_item   (i_item),
        .i_accept (w_accept),
        .o_cmd    (w_front_cmd)
    );

    // Command queue between the tree builder and the node table side.
    htld_fifo #(
        .WIDTH (CMD_W),
        .DEPTH (MID_DEPTH)
    ) u_cmd_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_accept),
        .i_wdata (w_front_cmd),
        .i_pop   (w_mid_pop),
        .o_rdata (w_mid_rdata),
        .o_full  (full),
        .o_empty (w_mid_empty),
        .o_count (w_mid_count)
    );

    htld_back #(
        .MAX_LEAVES (MAX_LEAVES),
        .OUT_DEPTH  (OUT_DEPTH)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_mid_cmd),
        .i_cmd_valid (!w_mid_empty),
        .o_cmd_pop   (w_mid_pop),
        .i_out_count (w_out_count),
        .o_out_valid (w_out_push),
        .o_out_item  (w_out_item)
    );

    // Result queue; the back side only issues work that has a slot reserved here.
    htld_fifo #(
        .WIDTH (RES_W),
        .DEPTH (OUT_DEPTH)
    ) u_res_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_out_push),
        .i_wdata (w_out_item),
        .i_pop   (pop),
        .o_rdata (w_res_rdata),
        .o_full  (w_out_full),
        .o_empty (empty),
        .o_count (w_out_count)
    );

    // A finished result must always find room in the result queue.
    a_res_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_out_push |-> !w_out_full)
        else $error("result written into a full result queue");

    // The back side only takes a command that is really waiting.
    a_cmd_present: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_mid_pop |-> (w_mid_count != '0))
        else $error("command taken from an empty command queue");

    // Once the tree is complete, the next transaction cannot add a node.
    a_no_write_after_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && w_front_cmd.op == OP_COMPLETE)
        |=> !(w_accept && w_front_cmd.op == OP_WRITE))
        else $error("node written right after tree completion");

endmodule

`default_nettype wire

// ===== src/htld_fifo.sv =====
// Small first-in first-out queue with registered storage and a fill count.
`timescale 1ns / 1ps
`default_nettype none

module htld_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_push,
    input  logic [WIDTH-1:0]           i_wdata,
    input  logic                       i_pop,
    output logic [WIDTH-1:0]           o_rdata,
    output logic                       o_full,
    output logic                       o_empty,
    output logic [$clog2(DEPTH+1)-1:0] o_count
);

    // DEPTH must be a power of two so the pointers wrap on their own.
    localparam int PW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PW-1:0]    r_wr_ptr;
    logic [PW-1:0]    r_rd_ptr;
    logic [CW-1:0]    r_count;
    logic             w_do_push;
    logic             w_do_pop;

    assign o_full    = (r_count == CW'(DEPTH));
    assign o_empty   = (r_count == '0);
    assign o_count   = r_count;
    assign o_rdata   = r_mem[r_rd_ptr];
    assign w_do_push = i_push && !o_full;
    assign w_do_pop  = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (w_do_push) begin
            r_mem[r_wr_ptr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_do_push) begin
                r_wr_ptr <= r_wr_ptr + PW'(1);
            end
            if (w_do_pop) begin
                r_rd_ptr <= r_rd_ptr + PW'(1);
            end
            if (w_do_push && !w_do_pop) begin
                r_count <= r_count + CW'(1);
            end else if (w_do_pop && !w_do_push) begin
                r_count <= r_count - CW'(1);
            end
        end
    end

endmodule

`default_nettype wire

// ===== src/htld_front.sv =====
// Tree builder: checks each transaction and keeps the post-order node stack.
`timescale 1ns / 1ps
`default_nettype none

module htld_front #(
    parameter int MAX_LEAVES = 256
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  htld_pkg::t_in_item i_item,
    input  logic              i_accept,
    output htld_pkg::t_cmd    o_cmd
);

    import htld_pkg::*;

    localparam int NODE_LIMIT = 2 * MAX_LEAVES - 1;
    localparam int DW         = $clog2(MAX_LEAVES + 1);
    localparam int CW         = $clog2(NODE_LIMIT + 1);
    localparam int SW         = $clog2(MAX_LEAVES);

    // The top of the stack lives in r_top; the memory holds the entries below it,
    // and r_second always carries the entry just under the top.
    logic [IDX_W-1:0]   r_stack [MAX_LEAVES];
    logic [DW-1:0]      r_depth;
    logic [CW-1:0]      r_count;
    logic               r_ready;
    logic [IDX_W-1:0]   r_top;
    logic               r_top_leaf;
    logic [ENTRY_W-1:0] r_top_entry;
    logic [IDX_W-1:0]   r_second;

    logic [DW-1:0]      n_depth;
    logic [CW-1:0]      n_count;
    logic               n_ready;
    logic [IDX_W-1:0]   n_top;
    logic               n_top_leaf;
    logic [ENTRY_W-1:0] n_top_entry;

    logic               w_push;
    logic [IDX_W-1:0]   w_node_idx;
    logic [ENTRY_W-1:0] w_leaf_entry;
    logic [ENTRY_W-1:0] w_join_entry;
    logic [DW-1:0]      w_next_depth;
    logic [SW-1:0]      w_rd_addr;

    assign w_node_idx   = IDX_W'(r_count);
    assign w_leaf_entry = {1'b1, {(ENTRY_W - 1 - SYM_W){1'b0}}, i_item.symbol};
    assign w_join_entry = {1'b0, r_second, r_top};

    always_comb begin
        o_cmd          = '0;
        o_cmd.op       = OP_REPORT;
        o_cmd.status   = ST_ERROR;
        n_depth        = r_depth;
        n_count        = r_count;
        n_ready        = r_ready;
        n_top          = r_top;
        n_top_leaf     = r_top_leaf;
        n_top_entry    = r_top_entry;
        w_push         = 1'b0;
        unique case (i_item.req_type)
            REQ_LEAF: begin
                if (!r_ready && r_depth < DW'(MAX_LEAVES) && r_count < CW'(NODE_LIMIT)) begin
                    o_cmd.op     = OP_WRITE;
                    o_cmd.status = ST_ACCEPT;
                    o_cmd.addr   = w_node_idx;
                    o_cmd.entry  = w_leaf_entry;
                    n_count      = r_count + CW'(1);
                    n_depth      = r_depth + DW'(1);
                    n_top        = w_node_idx;
                    n_top_leaf   = 1'b1;
                    n_top_entry  = w_leaf_entry;
                    w_push       = 1'b1;
                end
            end
            REQ_JOIN: begin
                priority if (r_ready || r_depth == '0) begin
                    o_cmd.status = ST_ERROR;
                end else if (r_depth == DW'(1)) begin
                    // A lone leaf is not a tree; the build carries on.
                    if (!r_top_leaf) begin
                        o_cmd.op     = OP_COMPLETE;
                        o_cmd.status = ST_DONE;
                        o_cmd.addr   = r_top;
                        o_cmd.entry  = r_top_entry;
                        n_ready      = 1'b1;
                    end
                end else if (r_count < CW'(NODE_LIMIT)) begin
                    o_cmd.op     = OP_WRITE;
                    o_cmd.status = ST_ACCEPT;
                    o_cmd.addr   = w_node_idx;
                    o_cmd.entry  = w_join_entry;
                    n_count      = r_count + CW'(1);
                    n_depth      = r_depth - DW'(1);
                    n_top        = w_node_idx;
                    n_top_leaf   = 1'b0;
                    n_top_entry  = w_join_entry;
                end
            end
            REQ_BIT: begin
                if (r_ready) begin
                    o_cmd.op       = OP_WALK;
                    o_cmd.status   = ST_ACCEPT;
                    o_cmd.code_bit = i_item.code_bit;
                end
            end
            REQ_CLEAR: begin
                o_cmd.status = ST_ACCEPT;
                n_depth      = '0;
                n_count      = '0;
                n_ready      = 1'b0;
            end
            default: begin
                o_cmd.status = ST_ERROR;
            end
        endcase
    end

    assign w_next_depth = i_accept ? n_depth : r_depth;
    assign w_rd_addr    = (w_next_depth >= DW'(2)) ? SW'(w_next_depth - DW'(2)) : '0;

    always_ff @(posedge i_clk) begin
        if (i_accept && w_push && r_depth != '0) begin
            r_stack[SW'(r_depth - DW'(1))] <= r_top;
        end
        if (i_accept && w_push) begin
            r_second <= r_top;
        end else begin
            r_second <= r_stack[w_rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_depth    <= '0;
            r_count    <= '0;
            r_ready    <= 1'b0;
            r_top      <= '0;
            r_top_leaf <= 1'b0;
        end else if (i_accept) begin
            r_depth    <= n_depth;
            r_count    <= n_count;
            r_ready    <= n_ready;
            r_top      <= n_top;
            r_top_leaf <= n_top_leaf;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_accept) begin
            r_top_entry <= n_top_entry;
        end
    end

endmodule

`default_nettype wire

// ===== src/htld_back.sv =====
// Node table and tree walker: writes nodes and decodes one code bit per cycle while the result queue has room.
`timescale 1ns / 1ps
`default_nettype none

module htld_back #(
    parameter int MAX_LEAVES = 256,
    parameter int OUT_DEPTH  = 4
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  htld_pkg::t_cmd                 i_cmd,
    input  logic                           i_cmd_valid,
    output logic                           o_cmd_pop,
    input  logic [$clog2(OUT_DEPTH+1)-1:0] i_out_count,
    output logic                           o_out_valid,
    output htld_pkg::t_out_item            o_out_item
);

    import htld_pkg::*;

    localparam int NODE_LIMIT = 2 * MAX_LEAVES - 1;
    localparam int NW         = $clog2(NODE_LIMIT);

    logic [ENTRY_W-1:0] r_nodes [NODE_LIMIT];
    logic [ENTRY_W-1:0] r_rd_data;
    logic [ENTRY_W-1:0] r_cur;
    logic [ENTRY_W-1:0] r_root;
    logic               r_b_valid;
    logic               r_b_walk;
    t_status            r_b_status;

    logic               w_fire;
    logic [ENTRY_W-1:0] w_b_next;
    logic [ENTRY_W-1:0] w_cur;
    logic [IDX_W-1:0]   w_next_idx;

    // Room is reserved for the result still in the second stage.
    assign w_fire    = i_cmd_valid && ((int'(i_out_count) + int'(r_b_valid)) < OUT_DEPTH);
    assign o_cmd_pop = w_fire;

    // A walk in the second stage hands its node straight to the next bit.
    assign w_b_next   = r_rd_data[LEAF_BIT] ? r_root : r_rd_data;
    assign w_cur      = (r_b_valid && r_b_walk) ? w_b_next : r_cur;
    assign w_next_idx = i_cmd.code_bit ? w_cur[IDX_W-1:0] : w_cur[2*IDX_W-1:IDX_W];

    always_ff @(posedge i_clk) begin
        if (w_fire && i_cmd.op == OP_WRITE) begin
            r_nodes[i_cmd.addr[NW-1:0]] <= i_cmd.entry;
        end
        if (w_fire && i_cmd.op == OP_WALK) begin
            r_rd_data <= r_nodes[w_next_idx[NW-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_fire && i_cmd.op == OP_COMPLETE) begin
            r_root <= i_cmd.entry;
            r_cur  <= i_cmd.entry;
        end else if (r_b_valid && r_b_walk) begin
            r_cur <= w_b_next;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_valid  <= 1'b0;
            r_b_walk   <= 1'b0;
            r_b_status <= ST_ACCEPT;
        end else begin
            r_b_valid  <= w_fire;
            r_b_walk   <= w_fire && (i_cmd.op == OP_WALK);
            r_b_status <= i_cmd.status;
        end
    end

    always_comb begin
        o_out_valid                = r_b_valid;
        o_out_item.status          = r_b_status;
        o_out_item.decoded_symbol  = '0;
        if (r_b_walk) begin
            if (r_rd_data[LEAF_BIT]) begin
                o_out_item.status         = ST_SYMBOL;
                o_out_item.decoded_symbol = r_rd_data[SYM_W-1:0];
            end else begin
                o_out_item.status = ST_ACCEPT;
            end
        end
    end

endmodule

`default_nettype wire

// ===== sim/tb.sv =====
// Self-checking testbench for the Huffman tree loader and bit-serial decoder.
`timescale 1ns / 1ps

// The bench rebuilds the tree in its own model as request transactions are
// accepted and predicts one result for each of them. Results are checked in
// order against that prediction as they are popped. A short directed table
// comes first. It covers the early code bit, a join on an empty stack, a
// single-leaf tree, tree items after completion and clears. Random episodes
// follow. Most of them clear the tree, build a random well-formed tree in post
// order and then stream code bits through it, with noise items mixed in.
// One episode fills the build stack to its limit, to hit the stack overflow
// and node-table-full errors.

module tb;

    import htld_pkg::*;

    localparam int MAX_LEAVES = 256;
    localparam int NODE_LIMIT = 2 * MAX_LEAVES - 1;
    localparam int CYCLE_LIMIT = 400000;
    localparam int HOLD_CYCLES = 300;
    localparam int MAX_PRINTED = 40;

    // One row of the directed table. Where typed is set, the expected result
    // is taken from the row instead of from the tree model.
    typedef struct {
        t_req_kind   kind;
        logic [7:0]  sym;
        logic        bit_val;
        bit          typed;
        t_status     st;
        logic [7:0]  dsym;
    } t_dir_row;

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       push = 1'b0;
    logic       pop = 1'b0;
    logic       full;
    logic       empty;
    t_in_item   i_item = '0;
    t_out_item  o_result;

    // Tree model state, kept at the widths of the block.
    logic [ENTRY_W-1:0] tree_nodes [0:NODE_LIMIT-1];
    logic [IDX_W-1:0]   build_stk  [0:MAX_LEAVES-1];
    logic [IDX_W-1:0]   node_used;
    logic [IDX_W-1:0]   stk_depth;
    logic               walk_ready;
    logic [IDX_W-1:0]   root_node;
    logic [IDX_W-1:0]   walk_node;

    // Results that the block still owes us, oldest first.
    t_out_item owed_results [$];

    int cycle_count = 0;
    int mismatches = 0;
    int items_sent = 0;
    int symbols_seen = 0;
    int trees_seen = 0;
    int errors_seen = 0;
    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    bit hold_req = 1'b0;
    int hold_left = 0;

    huffman_tree_load_and_decode #(
        .MAX_LEAVES (MAX_LEAVES)
    ) DUT (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .push     (push),
        .full     (full),
        .i_item   (i_item),
        .empty    (empty),
        .pop      (pop),
        .o_result (o_result)
    );

    always #10 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
    end

    // Watchdog: a hung handshake ends the run here.
    initial begin
        while (cycle_count < CYCLE_LIMIT) @(posedge i_clk);
        $display("timeout after %0d cycles, %0d results still owed", cycle_count,
                 owed_results.size());
        $display("TB_ERROR");
        $finish;
    end

    // Only the first few mismatches are printed so that a broken block does
    // not flood the log, but every one of them is counted.
    task automatic report_mismatch(input string what);
        if (mismatches < MAX_PRINTED) begin
            $display("mismatch at cycle %0d: %s", cycle_count, what);
        end
        mismatches++;
    endtask

    function automatic logic [ENTRY_W-1:0] node_at(input logic [IDX_W-1:0] idx);
        return (idx < NODE_LIMIT) ? tree_nodes[idx] : '0;
    endfunction

    // Applies one request to the tree model and returns the result it causes.
    // Every error leaves the model untouched.
    task automatic tree_step(input t_in_item it, output t_out_item res);
        logic [IDX_W-1:0]   top;
        logic [IDX_W-1:0]   lft;
        logic [IDX_W-1:0]   rgt;
        logic [IDX_W-1:0]   nxt;
        logic [ENTRY_W-1:0] entry;
        logic [ENTRY_W-1:0] child;
        res.status = ST_ERROR;
        res.decoded_symbol = '0;
        case (it.req_type)
            REQ_LEAF: begin
                if (!walk_ready && stk_depth < MAX_LEAVES && node_used < NODE_LIMIT) begin
                    tree_nodes[node_used] = {1'b1, 10'd0, it.symbol};
                    build_stk[stk_depth] = node_used;
                    node_used++;
                    stk_depth++;
                    res.status = ST_ACCEPT;
                end
            end
            REQ_JOIN: begin
                if (walk_ready || stk_depth == 0) begin
                    res.status = ST_ERROR;
                end else if (stk_depth == 1) begin
                    // The last entry becomes the root, unless the whole tree
                    // is one leaf, which cannot encode anything.
                    top = build_stk[0];
                    child = node_at(top);
                    if (!child[LEAF_BIT]) begin
                        walk_ready = 1'b1;
                        root_node = top;
                        walk_node = top;
                        res.status = ST_DONE;
                    end
                end else if (node_used < NODE_LIMIT) begin
                    rgt = build_stk[stk_depth - 1];
                    lft = build_stk[stk_depth - 2];
                    tree_nodes[node_used] = {1'b0, lft, rgt};
                    build_stk[stk_depth - 2] = node_used;
                    node_used++;
                    stk_depth--;
                    res.status = ST_ACCEPT;
                end
            end
            REQ_BIT: begin
                if (walk_ready) begin
                    entry = node_at(walk_node);
                    nxt = it.code_bit ? entry[IDX_W-1:0] : entry[2*IDX_W-1:IDX_W];
                    child = node_at(nxt);
                    if (child[LEAF_BIT]) begin
                        res.status = ST_SYMBOL;
                        res.decoded_symbol = child[SYM_W-1:0];
                        walk_node = root_node;
                    end else begin
                        walk_node = nxt;
                        res.status = ST_ACCEPT;
                    end
                end
            end
            default: begin
                node_used = '0;
                stk_depth = '0;
                walk_ready = 1'b0;
                root_node = '0;
                walk_node = '0;
                res.status = ST_ACCEPT;
            end
        endcase
    endtask

    // Offers one request transaction, starting and ending at a falling edge.
    // Push stays high from one item to the next unless the sender idles.
    task automatic send_request(input t_in_item it, input bit use_typed = 1'b0,
                                input t_out_item typed_res = '0);
        t_out_item res;
        while ($urandom_range(99) < send_idle_pct) begin
            push <= 1'b0;
            @(negedge i_clk);
        end
        push <= 1'b1;
        i_item <= it;
        @(posedge i_clk);
        while (full) @(posedge i_clk);
        tree_step(it, res);
        owed_results.push_back(use_typed ? typed_res : res);
        items_sent++;
        @(negedge i_clk);
    endtask

    // A request of the given kind with random payload bits.
    function automatic t_in_item make_item(input t_req_kind kind);
        t_in_item it;
        it.req_type = kind;
        it.symbol = SYM_W'($urandom_range(255));
        it.code_bit = 1'($urandom_range(1));
        return it;
    endfunction

    task automatic maybe_noise(input int pct);
        if ($urandom_range(99) < pct) begin
            send_request(make_item(t_req_kind'($urandom_range(3))));
        end
    endtask

    // Sender stops and waits until the block has returned everything owed.
    task automatic drain_results();
        push <= 1'b0;
        while (owed_results.size() != 0) @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    // One random episode: either pure noise, or a well-formed tree build in
    // post order followed by a stream of code bits, lightly salted with noise.
    task automatic random_episode();
        int leaves;
        int depth;
        int nbits;
        if ($urandom_range(99) < 15) begin
            repeat ($urandom_range(3, 12)) begin
                send_request(make_item(t_req_kind'($urandom_range(3))));
            end
        end else begin
            if ($urandom_range(9) != 0) send_request(make_item(REQ_CLEAR));
            leaves = ($urandom_range(9) == 0) ? $urandom_range(9, 40) : $urandom_range(2, 8);
            depth = 0;
            while (leaves > 0 || depth > 1) begin
                if (depth >= 2 && (leaves == 0 || $urandom_range(1) == 1)) begin
                    send_request(make_item(REQ_JOIN));
                    depth--;
                end else begin
                    send_request(make_item(REQ_LEAF));
                    depth++;
                    leaves--;
                end
                maybe_noise(3);
            end
            send_request(make_item(REQ_JOIN));
            nbits = $urandom_range(4, 40);
            repeat (nbits) begin
                send_request(make_item(REQ_BIT));
                maybe_noise(3);
            end
        end
    endtask

    task automatic random_traffic(input int count);
        int start;
        start = items_sent;
        while (items_sent - start < count) random_episode();
    endtask

    // Fills the build stack to its limit. With all joins at the end, the tree
    // is a comb, so the code bits lean towards 1 to walk deep into it.
    task automatic stress_full_tree();
        t_in_item it;
        send_request(make_item(REQ_CLEAR));
        repeat (MAX_LEAVES) send_request(make_item(REQ_LEAF));
        // Stack overflow: one leaf too many.
        send_request(make_item(REQ_LEAF));
        repeat (MAX_LEAVES - 1) send_request(make_item(REQ_JOIN));
        // The node table is now full, so another leaf is refused.
        send_request(make_item(REQ_LEAF));
        send_request(make_item(REQ_JOIN));
        send_request(make_item(REQ_JOIN));
        repeat (300) begin
            it = make_item(REQ_BIT);
            it.code_bit = ($urandom_range(19) != 0);
            send_request(it);
        end
    endtask

    function automatic t_dir_row row(input t_req_kind kind, input logic [7:0] sym,
                                     input logic bit_val, input bit typed,
                                     input t_status st, input logic [7:0] dsym);
        t_dir_row r;
        r.kind = kind;
        r.sym = sym;
        r.bit_val = bit_val;
        r.typed = typed;
        r.st = st;
        r.dsym = dsym;
        return r;
    endfunction

    // Result side: pop is driven at the falling edge. A long hold-off, asked
    // for by the stimulus, is counted down here cycle by cycle.
    initial begin
        forever begin
            @(negedge i_clk);
            if (hold_req) begin
                hold_left = HOLD_CYCLES;
                hold_req = 1'b0;
            end
            if (!i_rst_n) begin
                pop <= 1'b0;
            end else if (hold_left > 0) begin
                pop <= 1'b0;
                hold_left--;
            end else begin
                pop <= ($urandom_range(99) >= recv_idle_pct);
            end
        end
    end

    // Every popped result is compared with the oldest owed one.
    always @(posedge i_clk) begin
        t_out_item want;
        if (i_rst_n && pop && !empty) begin
            if (owed_results.size() == 0) begin
                report_mismatch($sformatf("result %p arrived with nothing owed", o_result));
            end else begin
                want = owed_results.pop_front();
                if (o_result.status !== want.status) begin
                    report_mismatch($sformatf("status %0d, expected %0d",
                                              o_result.status, want.status));
                end
                if (o_result.decoded_symbol !== want.decoded_symbol) begin
                    report_mismatch($sformatf("decoded symbol %02h, expected %02h",
                                              o_result.decoded_symbol, want.decoded_symbol));
                end
                case (want.status)
                    ST_SYMBOL: symbols_seen++;
                    ST_DONE:   trees_seen++;
                    ST_ERROR:  errors_seen++;
                    default: ;
                endcase
            end
        end
    end

    initial begin
        t_dir_row  dir_rows [$];
        t_in_item  it;
        t_out_item typed_res;

        foreach (tree_nodes[k]) tree_nodes[k] = '0;
        foreach (build_stk[k]) build_stk[k] = '0;
        node_used = '0;
        stk_depth = '0;
        walk_ready = 1'b0;
        root_node = '0;
        walk_node = '0;

        repeat (6) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed part. The first rows are plain enough to type the answer in.
        dir_rows.push_back(row(REQ_BIT,   8'h00, 1'b0, 1'b1, ST_ERROR,  8'h00));
        dir_rows.push_back(row(REQ_JOIN,  8'h00, 1'b0, 1'b1, ST_ERROR,  8'h00));
        dir_rows.push_back(row(REQ_LEAF,  8'h00, 1'b0, 1'b1, ST_ACCEPT, 8'h00));
        dir_rows.push_back(row(REQ_JOIN,  8'h00, 1'b0, 1'b1, ST_ERROR,  8'h00));
        dir_rows.push_back(row(REQ_LEAF,  8'hFF, 1'b1, 1'b1, ST_ACCEPT, 8'h00));
        dir_rows.push_back(row(REQ_JOIN,  8'h00, 1'b0, 1'b1, ST_ACCEPT, 8'h00));
        dir_rows.push_back(row(REQ_JOIN,  8'h00, 1'b0, 1'b1, ST_DONE,   8'h00));
        dir_rows.push_back(row(REQ_BIT,   8'h00, 1'b0, 1'b1, ST_SYMBOL, 8'h00));
        dir_rows.push_back(row(REQ_BIT,   8'hFF, 1'b1, 1'b1, ST_SYMBOL, 8'hFF));
        dir_rows.push_back(row(REQ_LEAF,  8'h55, 1'b0, 1'b1, ST_ERROR,  8'h00));
        dir_rows.push_back(row(REQ_JOIN,  8'h00, 1'b0, 1'b1, ST_ERROR,  8'h00));
        dir_rows.push_back(row(REQ_CLEAR, 8'h00, 1'b0, 1'b1, ST_ACCEPT, 8'h00));
        dir_rows.push_back(row(REQ_BIT,   8'h00, 1'b1, 1'b1, ST_ERROR,  8'h00));
        // A three-leaf tree, then a walk that is cut short by a clear.
        dir_rows.push_back(row(REQ_LEAF,  8'hA5, 1'b0, 1'b0, ST_ACCEPT, 8'h00));
        dir_rows.push_back(row(REQ_LEAF,  8'h5A, 1'b1, 1'b0, ST_ACCEPT, 8'h00));
        dir_rows.push_back(row(REQ_JOIN,  8'h00, 1'b0, 1'b0, ST_ACCEPT, 8'h00));
        dir_rows.push_back(row(REQ_LEAF,  8'h3C, 1'b0, 1'b0, ST_ACCEPT, 8'h00));
        dir_rows.push_back(row(REQ_JOIN,  8'h00, 1'b0, 1'b0, ST_ACCEPT, 8'h00));
        dir_rows.push_back(row(REQ_JOIN,  8'hFF, 1'b1, 1'b0, ST_ACCEPT, 8'h00));
        dir_rows.push_back(row(REQ_BIT,   8'h00, 1'b0, 1'b0, ST_ACCEPT, 8'h00));
        dir_rows.push_back(row(REQ_BIT,   8'h00, 1'b1, 1'b0, ST_ACCEPT, 8'h00));
        dir_rows.push_back(row(REQ_BIT,   8'h00, 1'b0, 1'b0, ST_ACCEPT, 8'h00));
        dir_rows.push_back(row(REQ_CLEAR, 8'h00, 1'b0, 1'b0, ST_ACCEPT, 8'h00));
        dir_rows.push_back(row(REQ_LEAF,  8'h81, 1'b1, 1'b0, ST_ACCEPT, 8'h00));
        dir_rows.push_back(row(REQ_CLEAR, 8'hFF, 1'b1, 1'b0, ST_ACCEPT, 8'h00));

        // First phase: the sender idles a little, the receiver a lot.
        send_idle_pct = 35;
        recv_idle_pct = 85;
        foreach (dir_rows[k]) begin
            it.req_type = dir_rows[k].kind;
            it.symbol = dir_rows[k].sym;
            it.code_bit = dir_rows[k].bit_val;
            typed_res.status = dir_rows[k].st;
            typed_res.decoded_symbol = dir_rows[k].dsym;
            send_request(it, dir_rows[k].typed, typed_res);
        end
        random_traffic(500);
        drain_results();

        // Second phase: the sender idles a lot, the receiver a little.
        send_idle_pct = 85;
        recv_idle_pct = 35;
        random_traffic(500);
        drain_results();

        // Third phase: nobody idles, apart from one long receiver hold-off at
        // the start so that the block backs up and raises full.
        send_idle_pct = 0;
        recv_idle_pct = 0;
        hold_req = 1'b1;
        stress_full_tree();
        random_traffic(150);
        drain_results();

        push <= 1'b0;
        repeat (8) @(posedge i_clk);
        if (owed_results.size() != 0) begin
            report_mismatch($sformatf("%0d results never arrived", owed_results.size()));
        end

        $display("sent %0d requests in three idle patterns, with a full-stack tree build",
                 items_sent);
        $display("checked %0d decoded symbols, %0d completed trees, %0d error answers",
                 symbols_seen, trees_seen, errors_seen);
        if (mismatches == 0) begin
            $display("TB_OK");
        end else begin
            $display("%0d mismatches", mismatches);
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule

// ===== huffman_tree_load_and_decode.f =====
src/htld_pkg.sv
src/htld_fifo.sv
src/htld_front.sv
src/htld_back.sv
src/huffman_tree_load_and_decode.sv
sim/tb.sv
